@@ rtl/arc_pkg.sv @@
package arc_pkg;
  localparam int CACHE_ENTRIES = 256;
  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  localparam logic [15:0] HTYPE_ETH = 16'd1;
  localparam logic [15:0] ARP_PTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] ARP_HLEN_ETH = 8'd6;
  localparam logic [7:0] ARP_PLEN_IPV4 = 8'd4;
  localparam logic [15:0] OPC_REQ = 16'd1;
  localparam logic [15:0] OPC_RPL = 16'd2;
  localparam logic [31:0] AGE_LIMIT_DEFAULT = 32'd300;
  localparam logic [10:0] MIN_FRAME_BYTES = 11'd28;

  localparam logic [2:0] CMD_FRAME = 3'd0;
  localparam logic [2:0] CMD_LOOKUP = 3'd1;
  localparam logic [2:0] CMD_ADD = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_TICK = 3'd4;
  localparam logic [2:0] CMD_REQUEST = 3'd5;
  localparam logic [2:0] CMD_GRAT = 3'd6;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  localparam logic [1:0] CFG_OWN_IP = 2'd0;
  localparam logic [1:0] CFG_OWN_MAC = 2'd1;
  localparam logic [1:0] CFG_AGE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_OWN = 2'd2;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_REQ = 2'd1;
  localparam logic [1:0] EV_REPLY = 2'd2;
  localparam logic [1:0] EV_GRAT = 2'd3;

  localparam logic [1:0] TXOP_REQUEST = 2'd1;
  localparam logic [1:0] TXOP_REPLY = 2'd2;

  typedef struct packed {
    logic [2:0] command;
    logic [10:0] frame_length;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0] hw_len;
    logic [7:0] proto_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] entry_ip;
    logic [47:0] entry_mac;
  } arc_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic tx_valid;
    logic [1:0] tx_opcode;
    logic [47:0] tx_dest_mac;
    logic [47:0] tx_target_mac;
    logic [31:0] tx_target_ip;
    logic hit;
    logic [47:0] hit_mac;
    logic [1:0] rx_event;
    logic [8:0] expired_count;
  } arc_out_t;

  typedef struct packed {
    logic [1:0] index;
    logic [47:0] data;
  } arc_cfg_t;
endpackage

@@ rtl/arc_if.sv @@
interface arc_in_if (input logic clk);
  logic valid;
  logic ready;
  arc_pkg::arc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface arc_out_if (input logic clk);
  logic valid;
  logic ready;
  arc_pkg::arc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface arc_cfg_if (input logic clk);
  logic valid;
  logic ready;
  arc_pkg::arc_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/arp_responder_with_cache_unit.sv @@
// ARP responder with address cache.
// in_ch carries one command per request; out_ch returns exactly one result
// per command. cfg_ch writes own_ip (0), own_mac (1) and age_limit_ticks (2)
// and is always ready; write it only while the block is idle.
// Commands that touch the cache walk the CACHE_ENTRIES slots through one
// compare unit, one slot per cycle, reading the slot memory through a
// registered port. Lookup and delete offer the result after the walk or at
// a hit, tick after the full walk. A frame or add that learns writes the hit
// slot, else a free slot, else after a second walk the oldest entry, and
// then offers the result. Request, gratuitous and frames that learn nothing
// offer it straight from idle.
// One command is in flight at a time; in_ready is low from acceptance until
// the result has been taken on out_ch, and the next command can be accepted
// in the cycle after that.
// A result is held in the output register until out_ready; the block then
// stalls with it. After synchronous reset (rst_n low) the cache is empty
// by valid bits, now_ticks is zero and age_limit_ticks is 300.
module arp_responder_with_cache_unit (
  input  logic clk,
  input  logic rst_n,
  arc_in_if.sink    in_ch,
  arc_out_if.source out_ch,
  arc_cfg_if.sink   cfg_ch
);
  localparam int IW = arc_pkg::IDX_W;
  localparam int CW = arc_pkg::CNT_W;
  localparam int CACHE_ENTRIES_M1 = arc_pkg::CACHE_ENTRIES - 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_FREE  = 7'b0000100,
    S_OLD   = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_TICK  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  arc_pkg::arc_in_t req_r;
  arc_pkg::arc_out_t res_r;
  logic [31:0] own_ip_r, age_r, now_r;
  logic [47:0] own_mac_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] scan_r;
  logic rd_ok_r;
  logic [IW-1:0] rd_idx_r;
  logic [CACHE_ENTRIES_M1:0] valid_r;

  logic [31:0] mem_ip [arc_pkg::CACHE_ENTRIES];
  logic [47:0] mem_mac [arc_pkg::CACHE_ENTRIES];
  logic [31:0] mem_stamp [arc_pkg::CACHE_ENTRIES];
  logic [31:0] rd_ip_r, rd_stamp_r;
  logic [47:0] rd_mac_r;

  logic found_r, pick_ok_r;
  logic [IW-1:0] pick_r;
  logic [31:0] best_r;
  logic [31:0] key_ip_r;
  logic [47:0] key_mac_r;
  logic [8:0] removed_r;

  logic wr_en;
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] rd_idx;
  logic [31:0] age;
  logic match;
  logic frame_bad;
  logic last;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data = res_r;

  assign rd_idx = scan_r[IW-1:0];
  assign age = now_r - rd_stamp_r;
  assign match = valid_r[rd_idx_r] && (rd_ip_r == key_ip_r);
  assign last = rd_ok_r && (rd_idx_r == IW'(arc_pkg::CACHE_ENTRIES - 1));
  assign wr_en = (state_r == S_WRITE);
  assign wr_idx = pick_r;

  always_comb begin
    frame_bad = (in_ch.data.frame_length < arc_pkg::MIN_FRAME_BYTES) ||
                (in_ch.data.hw_type != arc_pkg::HTYPE_ETH) ||
                (in_ch.data.proto_type != arc_pkg::ARP_PTYPE_IPV4) ||
                (in_ch.data.hw_len != arc_pkg::ARP_HLEN_ETH) ||
                (in_ch.data.proto_len != arc_pkg::ARP_PLEN_IPV4);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_ip[wr_idx] <= key_ip_r;
      mem_mac[wr_idx] <= key_mac_r;
      mem_stamp[wr_idx] <= now_r;
    end
    rd_ip_r <= mem_ip[rd_idx];
    rd_mac_r <= mem_mac[rd_idx];
    rd_stamp_r <= mem_stamp[rd_idx];
    rd_idx_r <= rd_idx;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.data.command)
            arc_pkg::CMD_FRAME: begin
              if (frame_bad || in_ch.data.src_ip == own_ip_r) state_nxt = S_OUT;
              else if (in_ch.data.src_ip != 32'd0) state_nxt = S_FIND;
              else state_nxt = S_OUT;
            end
            arc_pkg::CMD_LOOKUP, arc_pkg::CMD_ADD, arc_pkg::CMD_DELETE: state_nxt = S_FIND;
            arc_pkg::CMD_TICK: state_nxt = S_TICK;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_FIND: begin
        if (rd_ok_r && match) begin
          if (req_r.command == arc_pkg::CMD_FRAME || req_r.command == arc_pkg::CMD_ADD)
            state_nxt = S_WRITE;
          else state_nxt = S_OUT;
        end else if (last) begin
          if (req_r.command == arc_pkg::CMD_FRAME || req_r.command == arc_pkg::CMD_ADD) begin
            if (count_r == CW'(arc_pkg::CACHE_ENTRIES)) state_nxt = S_OLD;
            else state_nxt = S_FREE;
          end else state_nxt = S_OUT;
        end
      end
      S_FREE: state_nxt = S_WRITE;
      S_OLD: if (last) state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_OUT;
      S_TICK: if (last) state_nxt = S_OUT;
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [IW-1:0] free_idx;
  logic free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = arc_pkg::CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      own_ip_r <= '0;
      own_mac_r <= '0;
      age_r <= arc_pkg::AGE_LIMIT_DEFAULT;
      now_r <= '0;
      count_r <= '0;
      valid_r <= '0;
      scan_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.data.index)
          arc_pkg::CFG_OWN_IP: own_ip_r <= cfg_ch.data.data[31:0];
          arc_pkg::CFG_OWN_MAC: own_mac_r <= cfg_ch.data.data;
          arc_pkg::CFG_AGE: age_r <= cfg_ch.data.data[31:0];
          default: ;
        endcase
      end
      if (state_nxt != state_r) begin
        scan_r <= '0;
        rd_ok_r <= 1'b0;
      end else if (scan_r < CW'(arc_pkg::CACHE_ENTRIES)) begin
        scan_r <= scan_r + 1'b1;
        rd_ok_r <= 1'b1;
      end else begin
        rd_ok_r <= 1'b0;
      end
      if (state_r == S_IDLE && in_ch.valid && in_ch.data.command == arc_pkg::CMD_TICK)
        now_r <= now_r + 32'd1;
      if (state_r == S_FIND && rd_ok_r && match && req_r.command == arc_pkg::CMD_DELETE) begin
        valid_r[rd_idx_r] <= 1'b0;
        count_r <= count_r - 1'b1;
      end
      if (state_r == S_TICK && rd_ok_r && valid_r[rd_idx_r] && age > age_r) begin
        valid_r[rd_idx_r] <= 1'b0;
        count_r <= count_r - 1'b1;
      end
      if (state_r == S_WRITE && !found_r) begin
        valid_r[pick_r] <= 1'b1;
        if (pick_ok_r) count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        req_r <= in_ch.data;
        found_r <= 1'b0;
        pick_ok_r <= 1'b0;
        pick_r <= '0;
        best_r <= '0;
        removed_r <= '0;
        res_r <= '0;
        if (in_ch.data.command == arc_pkg::CMD_FRAME) begin
          key_ip_r <= in_ch.data.src_ip;
          key_mac_r <= in_ch.data.sender_mac;
        end else begin
          key_ip_r <= in_ch.data.entry_ip;
          key_mac_r <= in_ch.data.entry_mac;
        end
        case (in_ch.data.command)
          arc_pkg::CMD_FRAME: begin
            if (frame_bad) res_r.status <= arc_pkg::ST_ERR;
            else if (in_ch.data.src_ip == own_ip_r) res_r.status <= arc_pkg::ST_OWN;
            else if (in_ch.data.opcode == arc_pkg::OPC_REQ) begin
              res_r.rx_event <= arc_pkg::EV_REQ;
              if (in_ch.data.dst_ip == own_ip_r) begin
                res_r.tx_valid <= 1'b1;
                res_r.tx_opcode <= arc_pkg::TXOP_REPLY;
                res_r.tx_dest_mac <= in_ch.data.sender_mac;
                res_r.tx_target_mac <= in_ch.data.sender_mac;
                res_r.tx_target_ip <= in_ch.data.src_ip;
              end
            end else if (in_ch.data.opcode == arc_pkg::OPC_RPL) begin
              res_r.rx_event <= (in_ch.data.src_ip == in_ch.data.dst_ip) ?
                                arc_pkg::EV_GRAT : arc_pkg::EV_REPLY;
            end else res_r.status <= arc_pkg::ST_ERR;
          end
          arc_pkg::CMD_LOOKUP, arc_pkg::CMD_ADD, arc_pkg::CMD_TICK: ;
          arc_pkg::CMD_DELETE: res_r.status <= arc_pkg::ST_ERR;
          arc_pkg::CMD_REQUEST: begin
            if (in_ch.data.entry_ip == 32'hFFFF_FFFF || in_ch.data.entry_ip == own_ip_r)
              res_r.status <= arc_pkg::ST_ERR;
            else begin
              res_r.tx_valid <= 1'b1;
              res_r.tx_opcode <= arc_pkg::TXOP_REQUEST;
              res_r.tx_dest_mac <= 48'hFFFF_FFFF_FFFF;
              res_r.tx_target_ip <= in_ch.data.entry_ip;
            end
          end
          arc_pkg::CMD_GRAT: begin
            if (own_ip_r == 32'd0) res_r.status <= arc_pkg::ST_ERR;
            else begin
              res_r.tx_valid <= 1'b1;
              res_r.tx_opcode <= arc_pkg::TXOP_REQUEST;
              res_r.tx_dest_mac <= 48'hFFFF_FFFF_FFFF;
              res_r.tx_target_mac <= 48'hFFFF_FFFF_FFFF;
              res_r.tx_target_ip <= own_ip_r;
            end
          end
          default: res_r.status <= arc_pkg::ST_ERR;
        endcase
      end
      S_FIND: begin
        if (rd_ok_r && match) begin
          found_r <= 1'b1;
          pick_r <= rd_idx_r;
          if (req_r.command == arc_pkg::CMD_LOOKUP) begin
            res_r.hit <= 1'b1;
            res_r.hit_mac <= rd_mac_r;
          end
          if (req_r.command == arc_pkg::CMD_DELETE) res_r.status <= arc_pkg::ST_DONE;
        end
      end
      S_FREE: begin
        pick_r <= free_idx;
        pick_ok_r <= free_any;
      end
      S_OLD: begin
        if (rd_ok_r && (rd_idx_r == '0 || age > best_r)) begin
          best_r <= age;
          pick_r <= rd_idx_r;
        end
      end
      S_TICK: begin
        if (rd_ok_r && valid_r[rd_idx_r] && age > age_r) removed_r <= removed_r + 9'd1;
        if (last) res_r.expired_count <= removed_r +
                                         9'(valid_r[rd_idx_r] && age > age_r);
      end
      default: ;
    endcase
  end

  property p_busy_not_ready;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> !in_ch.ready;
  endproperty
  a_busy: assert property (p_busy_not_ready) else $error("ready while busy");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(arc_pkg::CACHE_ENTRIES)) else $error("entry count overflow");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(res_r)))
    else $error("result lost while stalled");

  a_hitmac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !res_r.hit) |-> (res_r.hit_mac == '0))
    else $error("hit_mac on miss");
endmodule
